[rtl/hvt_pkg.sv]
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DIV_W     = WORD_W + FRAC_BITS;
    localparam int CFG_REGS  = 8;
    localparam int CFG_AW    = $clog2(CFG_REGS);
    localparam int CFG_W     = 64;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [WORD_W-1:0] FIX_ONE = WORD_W'(1) << FRAC_BITS;

    localparam logic OP_PROJECT = 1'b0;
    localparam logic OP_COLUMN  = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [3:0] t_vec;
    typedef t_vec [3:0] t_mat;

    typedef struct packed {
        logic divide;
        t_vec v;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DIV_W-1:0]  num;
        logic [WORD_W-1:0] den;
        logic              neg;
    } t_lane;

    typedef struct packed {
        logic         valid;
        logic         divide;
        logic         wz;
        logic         sat;
        t_vec         r;
        t_lane [2:0]  lane;
    } t_dstg;

endpackage

`default_nettype wire

[rtl/hvt_front.sv]
// ----------------------------------------------------------------------------
// hvt_front
// Input item register: accepts items and classifies them by opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_opcode,
    input  wire  [127:0]      i_data,
    output logic              o_push,
    output hvt_pkg::t_cmd     o_cmd,
    input  wire               i_push_ready
);

    logic          r_valid;
    hvt_pkg::t_cmd r_cmd;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd.divide <= (i_opcode == hvt_pkg::OP_PROJECT);
            r_cmd.v      <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/hvt_queue.sv]
// ----------------------------------------------------------------------------
// hvt_queue
// Short command queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire hvt_pkg::t_cmd i_cmd,
    output logic              o_push_ready,
    output logic              o_valid,
    output hvt_pkg::t_cmd     o_cmd,
    input  wire               i_pop_ready
);

    hvt_pkg::t_cmd              r_mem [hvt_pkg::QDEPTH];
    logic [hvt_pkg::QAW-1:0]    r_wr;
    logic [hvt_pkg::QAW-1:0]    r_rd;
    logic [hvt_pkg::QAW:0]      r_cnt;
    logic                       push;
    logic                       pop;

    assign o_push_ready = (r_cnt != (hvt_pkg::QAW+1)'(hvt_pkg::QDEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rd];
    assign push         = i_push && o_push_ready;
    assign pop          = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/hvt_back.sv]
// ----------------------------------------------------------------------------
// hvt_back
// Multiply, sum, saturate, bit-per-stage divide and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire hvt_pkg::t_mat i_mat,
    input  wire               i_valid,
    input  wire hvt_pkg::t_cmd i_cmd,
    output logic              o_ready,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [127:0]      o_data,
    output logic [1:0]        o_user
);

    localparam int DW = hvt_pkg::DIV_W;
    localparam int FB = hvt_pkg::FRAC_BITS;

    logic en;

    logic                r_v1;
    logic                r_div1;
    logic signed [63:0]  r_p1 [16];
    logic                r_v2;
    logic                r_div2;
    logic signed [64:0]  r_s2 [8];
    logic                r_v3;
    logic                r_div3;
    logic                r_sat3;
    hvt_pkg::t_vec       r_r3;
    hvt_pkg::t_dstg      r_d [DW+1];
    logic                r_out_valid;
    logic [127:0]        r_out_data;
    logic [1:0]          r_out_user;

    hvt_pkg::t_vec       n_r3;
    logic                n_sat3;
    hvt_pkg::t_dstg      n_d0;
    logic [127:0]        n_out_data;
    logic [1:0]          n_out_user;

    function automatic hvt_pkg::t_lane div_step(input hvt_pkg::t_lane l);
        hvt_pkg::t_lane o;
        logic [32:0]    t;
        logic [32:0]    diff;
        logic           ge;
        t    = {l.rem, l.num[DW-1]};
        diff = t - {1'b0, l.den};
        ge   = (t >= {1'b0, l.den});
        o     = l;
        o.rem = ge ? diff[31:0] : t[31:0];
        o.num = {l.num[DW-2:0], ge};
        return o;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

    always_comb begin
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        n_sat3 = 1'b0;
        for (int c = 0; c < 4; c++) begin
            sum = 66'(r_s2[2*c]) + 66'(r_s2[2*c+1]);
            sh  = sum >>> FB;
            if ((&sh[65:31]) || !(|sh[65:31])) begin
                n_r3[c] = sh[31:0];
            end else begin
                n_sat3  = 1'b1;
                n_r3[c] = sh[65] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end
    end

    always_comb begin
        n_d0        = '0;
        n_d0.valid  = r_v3;
        n_d0.divide = r_div3;
        n_d0.wz     = r_div3 && (r_r3[3] == '0);
        n_d0.sat    = r_sat3;
        n_d0.r      = r_r3;
        for (int c = 0; c < 3; c++) begin
            n_d0.lane[c].rem = '0;
            n_d0.lane[c].num = {abs32(r_r3[c]), FB'(0)};
            n_d0.lane[c].den = abs32(r_r3[3]);
            n_d0.lane[c].neg = r_r3[c][31] ^ r_r3[3][31];
        end
    end

    always_comb begin
        hvt_pkg::t_dstg s;
        logic [DW-1:0]  q;
        logic [31:0]    val;
        logic           clip;
        logic           sat;
        s   = r_d[DW];
        sat = s.sat;
        for (int c = 0; c < 3; c++) begin
            q = s.lane[c].num;
            if (s.lane[c].neg) begin
                clip = (|q[DW-1:32]) || (q[31] && (|q[30:0]));
                val  = clip ? 32'h8000_0000 : 32'(-q[31:0]);
            end else begin
                clip = |q[DW-1:31];
                val  = clip ? 32'h7fff_ffff : q[31:0];
            end
            if (!s.divide) begin
                n_out_data[32*c +: 32] = s.r[c];
            end else if (s.wz) begin
                n_out_data[32*c +: 32] = '0;
            end else begin
                n_out_data[32*c +: 32] = val;
                sat = sat | clip;
            end
        end
        n_out_data[127:96] = s.divide ? hvt_pkg::FIX_ONE : s.r[3];
        n_out_user         = {sat, s.wz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= DW; k++) begin
                r_d[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_d[0]      <= n_d0;
            for (int k = 1; k <= DW; k++) begin
                r_d[k].valid <= r_d[k-1].valid;
                r_d[k].divide <= r_d[k-1].divide;
                r_d[k].wz    <= r_d[k-1].wz;
                r_d[k].sat   <= r_d[k-1].sat;
                r_d[k].r     <= r_d[k-1].r;
                for (int c = 0; c < 3; c++) begin
                    r_d[k].lane[c] <= div_step(r_d[k-1].lane[c]);
                end
            end
            r_out_valid <= r_d[DW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div1 <= i_cmd.divide;
            for (int c = 0; c < 4; c++) begin
                for (int t = 0; t < 4; t++) begin
                    r_p1[4*c+t] <= $signed(i_cmd.v[t]) *
                        $signed(i_cmd.divide ? i_mat[t][c] : i_mat[c][t]);
                end
            end
            r_div2 <= r_div1;
            for (int k = 0; k < 8; k++) begin
                r_s2[k] <= 65'(r_p1[2*k]) + 65'(r_p1[2*k+1]);
            end
            r_div3     <= r_div2;
            r_r3       <= n_r3;
            r_sat3     <= n_sat3;
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule

`default_nettype wire

[rtl/homogeneous_vertex_transform.sv]
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 Q16.16 vertex transform with optional perspective divide.
// ----------------------------------------------------------------------------
// One item is accepted per clock and one result leaves per clock when the
// output is not stalled. Each item passes the multiply, pairwise-sum and
// sum/saturate registers, then the 48-stage restoring divider (one quotient
// bit per stage) and the output register. A four-item queue separates the
// input register from the arithmetic pipeline. Matrix registers are to be
// written by the user only while the block is idle; it is not enforced.
`default_nettype none

module homogeneous_vertex_transform (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [127:0]                  s_axis_tdata,  // in_x, in_y, in_z, in_w
    input  wire                           s_axis_tuser,  // opcode
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [127:0]                  m_axis_tdata,  // out_x, out_y, out_z, out_w
    output logic [1:0]                    m_axis_tuser,  // w_was_zero, saturated
    input  wire                           i_cfg_we,
    input  wire  [hvt_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire  [hvt_pkg::CFG_W-1:0]     i_cfg_wdata
);

    logic [hvt_pkg::CFG_W-1:0] r_cfg [hvt_pkg::CFG_REGS];
    hvt_pkg::t_mat             mat;
    logic                      f_push;
    hvt_pkg::t_cmd             f_cmd;
    logic                      q_push_ready;
    logic                      q_valid;
    hvt_pkg::t_cmd             q_cmd;
    logic                      b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 64'd65536;
            r_cfg[1] <= '0;
            r_cfg[2] <= 64'd281474976710656;
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= 64'd65536;
            r_cfg[6] <= '0;
            r_cfg[7] <= 64'd281474976710656;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mat[i][0] = r_cfg[2*i][31:0];
            mat[i][1] = r_cfg[2*i][63:32];
            mat[i][2] = r_cfg[2*i+1][31:0];
            mat[i][3] = r_cfg[2*i+1][63:32];
        end
    end

    hvt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_push       (f_push),
        .o_cmd        (f_cmd),
        .i_push_ready (q_push_ready)
    );

    hvt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .i_cmd        (f_cmd),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd),
        .i_pop_ready  (b_ready)
    );

    hvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_ready (b_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[rtl/hvt_checker.sv]
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          m_axis_tvalid,
    input wire          m_axis_tready,
    input wire [127:0]  m_axis_tdata,
    input wire [1:0]    m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[95:0] == 96'd0 && m_axis_tdata[127:96] == hvt_pkg::FIX_ONE)
        else $error("zero w item carries nonzero components");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (.*);

`default_nettype wire
